@@ hdl/tlb_page_table_translator_unit_defines.svh @@
// Assertion macros used by the translator checker.
`ifndef TLB_PAGE_TABLE_TRANSLATOR_UNIT_DEFINES_SVH
`define TLB_PAGE_TABLE_TRANSLATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TLBPT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define TLBPT_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/tlbpt_pkg.sv @@
// Types, constants and helpers for the TLB and page-table translator.
package tlbpt_pkg;

   localparam int ADDR_W      = 16;
   localparam int PAGE_W      = 8;
   localparam int FRAME_W     = 8;
   localparam int FRAME_BYTES = 256;
   localparam int OFFSET_W    = $clog2(FRAME_BYTES);
   localparam int COUNT_W     = 32;
   localparam int STAMP_W     = 32;
   localparam int FREE_W      = 9;
   localparam int PAGE_SPAN   = 1 << PAGE_W;

   typedef logic [ADDR_W-1:0]   addr_type;
   typedef logic [PAGE_W-1:0]   page_type;
   typedef logic [FRAME_W-1:0]  frame_type;
   typedef logic [OFFSET_W-1:0] offset_type;
   typedef logic [COUNT_W-1:0]  count_type;
   typedef logic [STAMP_W-1:0]  stamp_type;
   typedef logic [FREE_W-1:0]   free_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_SCAN,
      ST_INSTALL,
      ST_EMIT
   } state_type;

   // page table write port
   typedef struct packed {
      logic      en;
      page_type  page;
      frame_type frame;
   } pt_write_type;

   // TLB install port (slot travels separately, its width is per instance)
   typedef struct packed {
      logic      en;
      page_type  page;
      frame_type frame;
      stamp_type stamp;
   } tlb_install_type;

   function automatic count_type sat_inc(input count_type v);
      count_type r;
      r = (v == '1) ? v : v + count_type'(1);
      return r;
   endfunction

endpackage

@@ hdl/tlbpt_channels.sv @@
// Valid/ready channel interfaces for translation requests and results.
interface tlbpt_req_if;
   import tlbpt_pkg::*;

   logic     valid;
   logic     ready;
   addr_type logical_address;

   modport source (output valid, output logical_address, input ready);
   modport sink   (input valid, input logical_address, output ready);
endinterface

interface tlbpt_rsp_if;
   import tlbpt_pkg::*;

   logic      valid;
   logic      ready;
   addr_type  physical_address;
   logic      tlb_hit;
   logic      page_fault;
   count_type hit_count;
   count_type fault_count;

   modport source (output valid, output physical_address, output tlb_hit,
                   output page_fault, output hit_count, output fault_count,
                   input ready);
   modport sink   (input valid, input physical_address, input tlb_hit,
                   input page_fault, input hit_count, input fault_count,
                   output ready);
endinterface

@@ hdl/tlbpt_page_table.sv @@
// Page table: frame RAM with registered read, plus per-page valid flops.
module tlbpt_page_table #(
   parameter int PAGE_COUNT = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rd_en,
   input  logic [$clog2(PAGE_COUNT)-1:0] rd_page,
   input  tlbpt_pkg::pt_write_type       wr,
   output tlbpt_pkg::frame_type          rd_frame,
   output logic                          rd_valid
);
   import tlbpt_pkg::*;

   localparam int PIDX_W = $clog2(PAGE_COUNT);

   frame_type              frame_mem [PAGE_COUNT];
   logic [PAGE_COUNT-1:0]  valid_ff;
   frame_type              rd_frame_ff;
   logic                   rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         frame_mem[wr.page[PIDX_W-1:0]] <= wr.frame;
      end
      if (rd_en) begin
         rd_frame_ff <= frame_mem[rd_page];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.page[PIDX_W-1:0]] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_page];
         end
      end
   end

   assign rd_frame = rd_frame_ff;
   assign rd_valid = rd_valid_ff;

endmodule

@@ hdl/tlbpt_tag_array.sv @@
// TLB: page/frame tags with parallel match, and a stamp RAM read one entry a cycle.
module tlbpt_tag_array #(
   parameter int TLB_ENTRIES = 16,
   parameter int IDX_W       = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  tlbpt_pkg::page_type        look_page,
   output logic                       hit,
   output tlbpt_pkg::frame_type       hit_frame,
   input  logic                       stamp_rd_en,
   input  logic [IDX_W-1:0]           stamp_rd_idx,
   output tlbpt_pkg::stamp_type       stamp_rd,
   input  tlbpt_pkg::tlb_install_type install,
   input  logic [IDX_W-1:0]           install_slot
);
   import tlbpt_pkg::*;

   page_type               page_ff  [TLB_ENTRIES];
   frame_type              frame_ff [TLB_ENTRIES];
   logic [TLB_ENTRIES-1:0] valid_ff;
   stamp_type              stamp_mem [TLB_ENTRIES];
   stamp_type              stamp_q_ff;
   logic                   stamp_v_ff;

   // lowest matching index wins
   always_comb begin
      hit       = 1'b0;
      hit_frame = '0;
      for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && (page_ff[i] == look_page)) begin
            hit       = 1'b1;
            hit_frame = frame_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (install.en) begin
         page_ff[install_slot]   <= install.page;
         frame_ff[install_slot]  <= install.frame;
         stamp_mem[install_slot] <= install.stamp;
      end
      if (stamp_rd_en) begin
         stamp_q_ff <= stamp_mem[stamp_rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         stamp_v_ff <= 1'b0;
      end else begin
         if (install.en) begin
            valid_ff[install_slot] <= 1'b1;
         end
         if (stamp_rd_en) begin
            stamp_v_ff <= valid_ff[stamp_rd_idx];
         end
      end
   end

   // never-installed entries read as a stamp of zero
   assign stamp_rd = stamp_v_ff ? stamp_q_ff : '0;

endmodule

@@ hdl/tlb_page_table_translator_unit.sv @@
// Top level of the TLB and page-table address translator.
//
// Translates a 16-bit logical address (page in bits 15..8, offset in 7..0) into a
// physical address, one item at a time. A TLB hit goes from acceptance to the result
// register in steps: accept, tag match, result load. On a miss the page-table RAM is
// read through a registered port, then the TLB stamp RAM is walked one entry per
// cycle to find the replacement victim (smallest stamp, lowest index on ties), and
// then the install is written back. A page fault hands out the next free frame in
// order; loading that frame is up to the caller. The result sits in an output
// register, so a new item is taken as soon as the sequencer is idle even when the
// previous result is still waiting. Hit and fault counters saturate at all ones.
// Page numbers are reduced modulo PAGE_COUNT before use. Reset clears all valid
// bits at once; there is no clearing pass.
module tlb_page_table_translator_unit #(
   parameter int TLB_ENTRIES = 16,
   parameter int PAGE_COUNT  = 256
) (
   input  logic        clock,
   input  logic        reset,
   tlbpt_req_if.sink   req_if,
   tlbpt_rsp_if.source rsp_if
);
   import tlbpt_pkg::*;

   localparam int IDX_W  = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
   localparam int PIDX_W = $clog2(PAGE_COUNT);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TLB_ENTRIES - 1);

   // page number modulo PAGE_COUNT, as a constant table
   logic [PIDX_W-1:0] page_lut [PAGE_SPAN];
   for (genvar g = 0; g < PAGE_SPAN; g++) begin : g_lut
      assign page_lut[g] = PIDX_W'(g % PAGE_COUNT);
   end

   // sequencer and item registers
   state_type         state_ff,  state_in;
   logic [PIDX_W-1:0] page_ff,   page_in;
   offset_type        offset_ff, offset_in;
   frame_type         frame_ff,  frame_in;
   logic              hit_ff,    hit_in;
   logic              fault_ff,  fault_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]  victim_ff, victim_in;
   stamp_type         best_ff,   best_in;

   // architectural state
   free_type  next_free_ff,   next_free_in;
   stamp_type use_clock_ff,   use_clock_in;
   count_type hit_total_ff,   hit_total_in;
   count_type fault_total_ff, fault_total_in;

   // result register
   logic      rsp_valid_ff,  rsp_valid_in;
   addr_type  rsp_addr_ff,   rsp_addr_in;
   logic      rsp_hit_ff,    rsp_hit_in;
   logic      rsp_fault_ff,  rsp_fault_in;
   count_type rsp_hits_ff,   rsp_hits_in;
   count_type rsp_faults_ff, rsp_faults_in;

   // submodule hookup
   logic              pt_rd_en;
   logic [PIDX_W-1:0] pt_rd_page;
   pt_write_type      pt_wr;
   frame_type         pt_frame;
   logic              pt_valid;
   logic              tag_hit;
   frame_type         tag_frame;
   logic              stamp_rd_en;
   logic [IDX_W-1:0]  stamp_rd_idx;
   stamp_type         stamp_rd;
   tlb_install_type   install;

   tlbpt_page_table #(
      .PAGE_COUNT (PAGE_COUNT)
   ) u_page_table (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (pt_rd_en),
      .rd_page  (pt_rd_page),
      .wr       (pt_wr),
      .rd_frame (pt_frame),
      .rd_valid (pt_valid)
   );

   tlbpt_tag_array #(
      .TLB_ENTRIES (TLB_ENTRIES),
      .IDX_W       (IDX_W)
   ) u_tag_array (
      .clock        (clock),
      .reset        (reset),
      .look_page    (PAGE_W'(page_ff)),
      .hit          (tag_hit),
      .hit_frame    (tag_frame),
      .stamp_rd_en  (stamp_rd_en),
      .stamp_rd_idx (stamp_rd_idx),
      .stamp_rd     (stamp_rd),
      .install      (install),
      .install_slot (victim_ff)
   );

   assign req_if.ready = (state_ff == ST_IDLE);
   assign pt_rd_page   = page_lut[req_if.logical_address[ADDR_W-1 -: PAGE_W]];

   always_comb begin
      state_in       = state_ff;
      page_in        = page_ff;
      offset_in      = offset_ff;
      frame_in       = frame_ff;
      hit_in         = hit_ff;
      fault_in       = fault_ff;
      rd_idx_in      = rd_idx_ff;
      victim_in      = victim_ff;
      best_in        = best_ff;
      next_free_in   = next_free_ff;
      use_clock_in   = use_clock_ff;
      hit_total_in   = hit_total_ff;
      fault_total_in = fault_total_ff;
      rsp_addr_in    = rsp_addr_ff;
      rsp_hit_in     = rsp_hit_ff;
      rsp_fault_in   = rsp_fault_ff;
      rsp_hits_in    = rsp_hits_ff;
      rsp_faults_in  = rsp_faults_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      pt_rd_en       = 1'b0;
      pt_wr          = '0;
      stamp_rd_en    = 1'b0;
      stamp_rd_idx   = rd_idx_ff;
      install        = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               page_in   = pt_rd_page;
               offset_in = req_if.logical_address[OFFSET_W-1:0];
               pt_rd_en  = 1'b1;
               state_in  = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (tag_hit) begin
               frame_in     = tag_frame;
               hit_in       = 1'b1;
               fault_in     = 1'b0;
               hit_total_in = sat_inc(hit_total_ff);
               state_in     = ST_EMIT;
            end else begin
               hit_in = 1'b0;
               if (pt_valid) begin
                  frame_in = pt_frame;
                  fault_in = 1'b0;
               end else begin
                  // page fault: take the next free frame
                  frame_in       = next_free_ff[FRAME_W-1:0];
                  fault_in       = 1'b1;
                  pt_wr.en       = 1'b1;
                  pt_wr.page     = PAGE_W'(page_ff);
                  pt_wr.frame    = next_free_ff[FRAME_W-1:0];
                  next_free_in   = next_free_ff + free_type'(1);
                  fault_total_in = sat_inc(fault_total_ff);
               end
               stamp_rd_en  = 1'b1;
               stamp_rd_idx = '0;
               rd_idx_in    = '0;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // stamp for rd_idx_ff has arrived; keep the first strict minimum
            if ((rd_idx_ff == '0) || (stamp_rd < best_ff)) begin
               best_in   = stamp_rd;
               victim_in = rd_idx_ff;
            end
            if (rd_idx_ff == LAST_IDX) begin
               state_in = ST_INSTALL;
            end else begin
               stamp_rd_en  = 1'b1;
               stamp_rd_idx = rd_idx_ff + IDX_W'(1);
               rd_idx_in    = rd_idx_ff + IDX_W'(1);
            end
         end
         ST_INSTALL: begin
            use_clock_in  = use_clock_ff + stamp_type'(1);
            install.en    = 1'b1;
            install.page  = PAGE_W'(page_ff);
            install.frame = frame_ff;
            install.stamp = use_clock_ff + stamp_type'(1);
            state_in      = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = {frame_ff, offset_ff};
               rsp_hit_in    = hit_ff;
               rsp_fault_in  = fault_ff;
               rsp_hits_in   = hit_total_ff;
               rsp_faults_in = fault_total_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         next_free_ff   <= '0;
         use_clock_ff   <= '0;
         hit_total_ff   <= '0;
         fault_total_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         next_free_ff   <= next_free_in;
         use_clock_ff   <= use_clock_in;
         hit_total_ff   <= hit_total_in;
         fault_total_ff <= fault_total_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff       <= page_in;
      offset_ff     <= offset_in;
      frame_ff      <= frame_in;
      hit_ff        <= hit_in;
      fault_ff      <= fault_in;
      rd_idx_ff     <= rd_idx_in;
      victim_ff     <= victim_in;
      best_ff       <= best_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_fault_ff  <= rsp_fault_in;
      rsp_hits_ff   <= rsp_hits_in;
      rsp_faults_ff <= rsp_faults_in;
   end

   assign rsp_if.valid            = rsp_valid_ff;
   assign rsp_if.physical_address = rsp_addr_ff;
   assign rsp_if.tlb_hit          = rsp_hit_ff;
   assign rsp_if.page_fault       = rsp_fault_ff;
   assign rsp_if.hit_count        = rsp_hits_ff;
   assign rsp_if.fault_count      = rsp_faults_ff;

endmodule

@@ hdl/tlbpt_checker.sv @@
// Port-level checker for the translator, bound to the top level.
`include "tlb_page_table_translator_unit_defines.svh"

module tlbpt_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic                 rsp_hit,
   input logic                 rsp_fault,
   input tlbpt_pkg::count_type rsp_hits,
   input tlbpt_pkg::count_type rsp_faults
);
   import tlbpt_pkg::*;

   logic      req_acc;
   logic      rsp_acc;
   logic [1:0] pend_ff,   pend_in;
   count_type  hits_ff,   hits_in;
   count_type  faults_ff, faults_in;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   always_comb begin
      pend_in   = pend_ff + 2'(req_acc) - 2'(rsp_acc);
      hits_in   = rsp_acc ? rsp_hits   : hits_ff;
      faults_in = rsp_acc ? rsp_faults : faults_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff   <= '0;
         hits_ff   <= '0;
         faults_ff <= '0;
      end else begin
         pend_ff   <= pend_in;
         hits_ff   <= hits_in;
         faults_ff <= faults_in;
      end
   end

   // one item in work at a time
   `TLBPT_ASSERT_NXT(a_busy_after_accept, clock, reset, req_acc, !req_ready, "ready after accept")

   // no result without an item accepted and not yet delivered
   `TLBPT_ASSERT_IMP(a_no_spurious, clock, reset, rsp_valid, pend_ff != 2'd0, "spurious result")

   // running hit count moves by exactly the hit flag until it saturates
   `TLBPT_ASSERT_IMP(a_hit_count, clock, reset, rsp_acc && (hits_ff != '1), rsp_hits == hits_ff + count_type'(rsp_hit), "hit count step")

   // running fault count moves by exactly the fault flag until it saturates
   `TLBPT_ASSERT_IMP(a_fault_count, clock, reset, rsp_acc && (faults_ff != '1), rsp_faults == faults_ff + count_type'(rsp_fault), "fault count step")

endmodule

bind tlb_page_table_translator_unit tlbpt_checker u_tlbpt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_if.valid),
   .req_ready  (req_if.ready),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .rsp_hit    (rsp_if.tlb_hit),
   .rsp_fault  (rsp_if.page_fault),
   .rsp_hits   (rsp_if.hit_count),
   .rsp_faults (rsp_if.fault_count)
);
